// ===== sv/slc_pkg.sv =====
package slc_pkg;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	localparam int OUT_WIDTH = 32;

	typedef enum logic [1:0] {
		HOLD_NONE  = 2'd0,
		HOLD_SLASH = 2'd1,
		HOLD_STAR  = 2'd2
	} hold_t;

	typedef enum logic [1:0] {
		ST_CODE    = 2'd0,
		ST_COMMENT = 2'd1,
		ST_QUIET   = 2'd2
	} line_state_t;

	// Count events raised by one byte; bit 0 is the code-line counter.
	typedef struct packed {
		logic comments;
		logic comment_line;
		logic blank_line;
		logic code_line;
	} bump_t;

	localparam int IX_CODE     = 0;
	localparam int IX_BLANK    = 1;
	localparam int IX_CMLINE   = 2;
	localparam int IX_COMMENTS = 3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_file;
	} text_item_t;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] code_lines;
		logic [OUT_WIDTH-1:0] blank_lines;
		logic [OUT_WIDTH-1:0] comment_lines;
		logic [OUT_WIDTH-1:0] comment_count;
		logic [OUT_WIDTH-1:0] total_code_lines;
		logic [OUT_WIDTH-1:0] total_blank_lines;
		logic [OUT_WIDTH-1:0] total_comment_lines;
		logic [OUT_WIDTH-1:0] total_comments;
	} count_item_t;

endpackage

// ===== sv/slc_line_fsm.sv =====
module slc_line_fsm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  slc_pkg::text_item_t item,
	output slc_pkg::bump_t     bumps
);
	import slc_pkg::*;

	hold_t       hold_q, hold_n;
	line_state_t line_q, line_n;
	line_state_t prev_q, prev_n;
	logic        cac_q, cac_n;
	logic        fresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_NONE;
			line_q <= ST_QUIET;
			prev_q <= ST_QUIET;
			cac_q  <= 1'b0;
		end else if (step) begin
			hold_q <= hold_n;
			line_q <= line_n;
			prev_q <= prev_n;
			cac_q  <= cac_n;
		end
	end

	always_comb begin
		hold_n = HOLD_NONE;
		line_n = line_q;
		prev_n = prev_q;
		cac_n  = cac_q;
		bumps  = '0;
		fresh  = 1'b0;

		if (item.end_of_file) begin
			// flush a held character as code
			if (hold_q != HOLD_NONE && line_n == ST_QUIET) begin
				prev_n = ST_QUIET;
				line_n = ST_CODE;
			end
		end else begin
			fresh = 1'b1;
			unique case (hold_q)
				HOLD_SLASH: begin
					if (item.text_byte == CH_STAR) begin
						prev_n = line_n;
						line_n = ST_COMMENT;
						fresh  = 1'b0;
					end else if (line_n == ST_QUIET) begin
						prev_n = ST_QUIET;
						line_n = ST_CODE;
					end
				end
				HOLD_STAR: begin
					if (item.text_byte == CH_SLASH) begin
						bumps.comments = 1'b1;
						if (prev_n == ST_CODE) begin
							cac_n = 1'b1;
						end
						prev_n = ST_COMMENT;
						line_n = ST_QUIET;
						fresh  = 1'b0;
					end else if (line_n == ST_QUIET) begin
						prev_n = ST_QUIET;
						line_n = ST_CODE;
					end
				end
				default: ;
			endcase

			if (fresh) begin
				case (item.text_byte) inside
					CH_NL: begin
						if (line_n == ST_CODE) begin
							bumps.code_line = 1'b1;
						end else if (line_n == ST_COMMENT) begin
							bumps.comment_line = 1'b1;
						end else if (prev_n == ST_COMMENT) begin
							if (cac_n) begin
								bumps.code_line = 1'b1;
							end else begin
								bumps.comment_line = 1'b1;
							end
						end else begin
							bumps.blank_line = 1'b1;
						end
						if (line_n != ST_COMMENT) begin
							prev_n = ST_QUIET;
							line_n = ST_QUIET;
						end
						cac_n = 1'b0;
					end
					CH_SLASH: hold_n = HOLD_SLASH;
					CH_STAR:  hold_n = HOLD_STAR;
					CH_SP, CH_TAB: ;
					default: begin
						if (line_n == ST_QUIET) begin
							prev_n = ST_QUIET;
							line_n = ST_CODE;
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== sv/source_line_classifier_core.sv =====
// Source line classifier.
// The text channel (text_valid, text_stall, text) moves one byte of source
// text, or an end-of-file marker, per transfer. Every byte updates the line
// state: spaces and tabs are skipped, slash-star and star-slash pairs open
// and close comments, and a newline classifies the finished line as code,
// comment or blank. An end-of-file transfer produces one transfer on the
// count channel (counts_valid, counts_stall, counts) with the per-file
// counts and the running totals, then clears the per-file counts.
// Throughput is one byte per cycle while no end-of-file marker waits. A byte
// goes through the input register, then updates the state and counters;
// the result of an end-of-file marker is held in an output register that
// drives counts. While that register holds a result that the receiver
// stalls, only a second end-of-file marker waits in the input register;
// text bytes keep flowing up to it and then wait behind it. Reset clears
// the line state, the held character, all counters and both valid flags.
// Counters are COUNT_WIDTH bits and saturate; count fields carry the low 32 bits.
module source_line_classifier_core #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_stall,
	input  slc_pkg::text_item_t  text,
	output logic                 counts_valid,
	input  logic                 counts_stall,
	output slc_pkg::count_item_t counts
);
	import slc_pkg::*;

	localparam int NCNT = 4;

	logic                   valid_s1;
	text_item_t             item_s1;
	logic                   advance;
	logic                   step;
	bump_t                  bumps;
	logic [NCNT-1:0]        bump_vec;
	logic [COUNT_WIDTH-1:0] file_q  [NCNT];
	logic [COUNT_WIDTH-1:0] total_q [NCNT];
	logic [COUNT_WIDTH-1:0] total_n [NCNT];
	logic                   res_valid_q;
	count_item_t            res_q;

	function automatic logic [COUNT_WIDTH-1:0] sat_add(
		input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b
	);
		logic [COUNT_WIDTH:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
		logic [63:0] ext;
		ext = 64'(v);
		return ext[OUT_WIDTH-1:0];
	endfunction

	// An end-of-file item needs an output register that is free or being taken; a byte in the input register never waits.
	assign advance    = valid_s1 && (!item_s1.end_of_file || !res_valid_q || !counts_stall);
	assign step       = advance;
	assign text_stall = valid_s1 && !advance;

	// Input register: load whenever the stage is not held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!text_stall) begin
			item_s1 <= text;
		end
	end

	slc_line_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.bumps  (bumps)
	);

	assign bump_vec = bumps;

	always_comb begin
		for (int i = 0; i < NCNT; i++) begin
			total_n[i] = sat_add(total_q[i], file_q[i]);
		end
	end

	// Per-file counters and running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCNT; i++) begin
				file_q[i]  <= '0;
				total_q[i] <= '0;
			end
		end else if (step) begin
			if (item_s1.end_of_file) begin
				// fold into totals, then drop the per-file counts
				for (int i = 0; i < NCNT; i++) begin
					total_q[i] <= total_n[i];
					file_q[i]  <= '0;
				end
			end else begin
				for (int i = 0; i < NCNT; i++) begin
					if (bump_vec[i] && file_q[i] != '1) begin
						file_q[i] <= file_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// Output register: hold the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && item_s1.end_of_file) begin
			res_valid_q <= 1'b1;
		end else if (!counts_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.end_of_file) begin
			res_q.code_lines          <= to_out(file_q[IX_CODE]);
			res_q.blank_lines         <= to_out(file_q[IX_BLANK]);
			res_q.comment_lines       <= to_out(file_q[IX_CMLINE]);
			res_q.comment_count       <= to_out(file_q[IX_COMMENTS]);
			res_q.total_code_lines    <= to_out(total_n[IX_CODE]);
			res_q.total_blank_lines   <= to_out(total_n[IX_BLANK]);
			res_q.total_comment_lines <= to_out(total_n[IX_CMLINE]);
			res_q.total_comments      <= to_out(total_n[IX_COMMENTS]);
		end
	end

	assign counts_valid = res_valid_q;
	assign counts       = res_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import slc_pkg::*;

	localparam int COUNT_WIDTH = 32;
	localparam int HALF_PERIOD = 6;
	localparam int HOLD_CYCLES = 240;
	localparam int PHASE_ITEMS = 125;
	localparam int PHASE_FILES = 10;
	localparam int SETTLE_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	text_item_t  text = '0;
	logic        counts_valid;
	logic        counts_stall = 1'b0;
	count_item_t counts;

	source_line_classifier_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text(text),
		.counts_valid(counts_valid),
		.counts_stall(counts_stall),
		.counts(counts)
	);

	// Free-running clock, 12 ns period.
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Text bytes and end-of-file markers waiting to be offered.
	text_item_t  text_q[$];
	// Count reports that end-of-file transfers have produced and the
	// receiver has not yet taken, oldest first.
	count_item_t file_reports[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int items_queued = 0;
	int files_queued = 0;
	int items_taken = 0;
	int reports_seen = 0;
	int errors = 0;
	logic text_took = 1'b0;

	// Shadow of the classifier: held character, line state machine and the
	// per-file and running counters, all at the block's widths.
	hold_t                  held = HOLD_NONE;
	line_state_t            cur_state = ST_QUIET;
	line_state_t            prev_state = ST_QUIET;
	bit                     code_before_comment = 1'b0;
	logic [COUNT_WIDTH-1:0] file_count [4] = '{default: '0};
	logic [COUNT_WIDTH-1:0] total_count [4] = '{default: '0};

	// Saturating add: clamp at all ones once the carry comes out.
	function automatic logic [COUNT_WIDTH-1:0] sat_add(logic [COUNT_WIDTH-1:0] a,
			logic [COUNT_WIDTH-1:0] b);
		logic [COUNT_WIDTH:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
	endfunction

	function automatic void bump(int ix);
		file_count[ix] = sat_add(file_count[ix], COUNT_WIDTH'(1));
	endfunction

	// An ordinary character only matters on a line that has seen nothing yet.
	function automatic void mark_code();
		if (cur_state == ST_QUIET) begin
			prev_state = ST_QUIET;
			cur_state = ST_CODE;
		end
	endfunction

	// Advance the shadow by one accepted transfer; an end-of-file marker
	// queues the count report that the block must produce for it.
	function automatic void classify_transfer(text_item_t t);
		count_item_t r;
		logic [7:0]  b;
		bit          paired;
		b = t.text_byte;
		paired = 1'b0;
		if (t.end_of_file) begin
			// A character still held at end of file is plain code.
			if (held != HOLD_NONE)
				mark_code();
			held = HOLD_NONE;
			for (int i = 0; i < 4; i++)
				total_count[i] = sat_add(total_count[i], file_count[i]);
			r.code_lines          = file_count[IX_CODE][OUT_WIDTH-1:0];
			r.blank_lines         = file_count[IX_BLANK][OUT_WIDTH-1:0];
			r.comment_lines       = file_count[IX_CMLINE][OUT_WIDTH-1:0];
			r.comment_count       = file_count[IX_COMMENTS][OUT_WIDTH-1:0];
			r.total_code_lines    = total_count[IX_CODE][OUT_WIDTH-1:0];
			r.total_blank_lines   = total_count[IX_BLANK][OUT_WIDTH-1:0];
			r.total_comment_lines = total_count[IX_CMLINE][OUT_WIDTH-1:0];
			r.total_comments      = total_count[IX_COMMENTS][OUT_WIDTH-1:0];
			file_reports.push_back(r);
			for (int i = 0; i < 4; i++)
				file_count[i] = '0;
			// Line state deliberately survives: an open comment carries over.
		end else begin
			if (held == HOLD_SLASH && b == CH_STAR) begin
				// Comment opens; remember what the line was before it.
				prev_state = cur_state;
				cur_state = ST_COMMENT;
				paired = 1'b1;
			end else if (held == HOLD_STAR && b == CH_SLASH) begin
				// Comment closes, counted even if none was open.
				bump(IX_COMMENTS);
				if (prev_state == ST_CODE)
					code_before_comment = 1'b1;
				prev_state = ST_COMMENT;
				cur_state = ST_QUIET;
				paired = 1'b1;
			end else if (held != HOLD_NONE) begin
				mark_code();
			end
			held = HOLD_NONE;
			if (!paired) begin
				case (b)
					CH_NL: begin
						if (cur_state == ST_CODE)
							bump(IX_CODE);
						else if (cur_state == ST_COMMENT)
							bump(IX_CMLINE);
						else if (prev_state == ST_COMMENT)
							bump(code_before_comment ? IX_CODE : IX_CMLINE);
						else
							bump(IX_BLANK);
						if (cur_state != ST_COMMENT) begin
							prev_state = ST_QUIET;
							cur_state = ST_QUIET;
						end
						code_before_comment = 1'b0;
					end
					CH_SLASH: held = HOLD_SLASH;
					CH_STAR:  held = HOLD_STAR;
					CH_SP, CH_TAB: ;
					default:  mark_code();
				endcase
			end
		end
	endfunction

	function automatic void check_field(string name, logic [OUT_WIDTH-1:0] want_v,
			logic [OUT_WIDTH-1:0] got);
		if (got !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got);
			errors++;
		end
	endfunction

	// Rising edge: check the count transfer first, then fold the text
	// transfer of the same edge into the shadow. A report can never leave
	// on the edge that takes its marker, so this order is safe.
	always @(posedge clk) begin
		count_item_t want;
		text_took <= arst_n && text_valid && !text_stall;
		if (arst_n && counts_valid && !counts_stall) begin
			reports_seen++;
			if (file_reports.size() == 0) begin
				$error("count transfer with no end of file pending: code_lines=%0d",
					counts.code_lines);
				errors++;
			end else begin
				want = file_reports.pop_front();
				check_field("code_lines", want.code_lines, counts.code_lines);
				check_field("blank_lines", want.blank_lines, counts.blank_lines);
				check_field("comment_lines", want.comment_lines, counts.comment_lines);
				check_field("comment_count", want.comment_count, counts.comment_count);
				check_field("total_code_lines", want.total_code_lines,
					counts.total_code_lines);
				check_field("total_blank_lines", want.total_blank_lines,
					counts.total_blank_lines);
				check_field("total_comment_lines", want.total_comment_lines,
					counts.total_comment_lines);
				check_field("total_comments", want.total_comments, counts.total_comments);
			end
		end
		if (arst_n && text_valid && !text_stall) begin
			items_taken++;
			classify_transfer(text);
		end
	end

	// Falling edge: advance to the next byte once the current one has been
	// taken, or go idle by chance; hold the payload while it is stalled.
	always @(negedge clk) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
		end else if (!text_valid || text_took) begin
			if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				text <= text_q.pop_front();
				text_valid <= 1'b1;
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	// The hold-off is counted here so the sender keeps offering meanwhile.
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			counts_stall <= 1'b1;
		end else begin
			counts_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic push_byte(logic [7:0] b);
		text_item_t t;
		t.text_byte = b;
		t.end_of_file = 1'b0;
		text_q.push_back(t);
		items_queued++;
	endtask

	// The byte beside the marker is don't-care; randomize it anyway.
	task automatic push_eof();
		text_item_t t;
		t.text_byte = 8'($urandom_range(255));
		t.end_of_file = 1'b1;
		text_q.push_back(t);
		items_queued++;
		files_queued++;
	endtask

	task automatic push_open();
		push_byte(CH_SLASH);
		push_byte(CH_STAR);
	endtask

	task automatic push_close();
		push_byte(CH_STAR);
		push_byte(CH_SLASH);
	endtask

	// Identifier-ish text: letters, digits, punctuation, the odd space.
	task automatic push_word(int n);
		repeat (n) begin
			case ($urandom_range(4))
				0, 1: push_byte(8'(8'h61 + $urandom_range(25)));
				2:    push_byte(8'(8'h30 + $urandom_range(9)));
				3:    push_byte(8'h3B);
				default: push_byte(CH_SP);
			endcase
		end
	endtask

	// One line of plausible source with random content; now and then noise,
	// stray comment delimiters or an end of file in the middle of the line.
	task automatic queue_random_line();
		repeat ($urandom_range(2))
			push_byte($urandom_range(1) ? CH_SP : CH_TAB);
		case ($urandom_range(9))
			0: ;
			1, 2: push_word($urandom_range(1, 5));
			3: begin
				push_open();
				push_word($urandom_range(0, 3));
				push_close();
			end
			4: begin
				push_word($urandom_range(1, 3));
				push_open();
				push_word($urandom_range(0, 2));
				push_close();
			end
			5: begin
				push_open();
				push_word($urandom_range(0, 2));
				push_close();
				push_word($urandom_range(1, 3));
			end
			6: begin
				push_open();
				push_word($urandom_range(0, 2));
				push_byte(CH_NL);
				push_word($urandom_range(0, 2));
				push_close();
			end
			7: begin
				push_open();
				push_word($urandom_range(0, 3));
			end
			8: begin
				repeat ($urandom_range(2, 6)) begin
					case ($urandom_range(3))
						0: push_byte(CH_SLASH);
						1: push_byte(CH_STAR);
						2: push_byte(8'(8'h61 + $urandom_range(25)));
						default: push_byte(CH_SP);
					endcase
				end
			end
			default: begin
				repeat ($urandom_range(1, 4))
					push_byte(8'($urandom_range(255)));
			end
		endcase
		if ($urandom_range(5) == 0) begin
			push_eof();
		end else begin
			push_byte(CH_NL);
			if ($urandom_range(2) == 0)
				push_eof();
		end
	endtask

	// Wait until every queued byte is taken and every report has arrived.
	task automatic drain();
		while (text_q.size() != 0 || text_valid || file_reports.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int start_items;
		int start_files;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme bytes, blank and whitespace-only lines, a full
		// comment line, a close with nothing open, characters held at end of
		// file and a comment left open into the next file.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_NL);
		push_byte(CH_NL);
		push_byte(CH_SP);
		push_byte(CH_TAB);
		push_byte(CH_NL);
		push_open();
		push_byte(8'h78);
		push_close();
		push_byte(CH_NL);
		push_close();
		push_byte(8'h61);
		push_byte(CH_SLASH);
		push_eof();
		push_open();
		push_eof();
		push_close();
		push_byte(CH_NL);
		push_byte(CH_STAR);
		push_eof();
		drain();

		// Random phases: free flow, idle sender, stalling receiver, both.
		for (int phase = 0; phase < 4; phase++) begin
			@(posedge clk);
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 57; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 57; end
				default: begin send_idle_pct = 27; stall_pct = 27; end
			endcase
			start_items = items_queued;
			start_files = files_queued;
			while (items_queued - start_items < PHASE_ITEMS
					|| files_queued - start_files < PHASE_FILES)
				queue_random_line();
			drain();
		end

		// Back-pressure: hold the receiver off while short files keep
		// coming, so the output register fills and the text input stalls.
		@(posedge clk);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req++;
		repeat (14) begin
			push_word(2);
			push_eof();
		end
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("Took %0d text transfers across %0d files and checked %0d count reports,",
			items_taken, files_queued, reports_seen);
		$display("under free flow, random idling and stalls, and a long receiver hold-off.");
		if (errors == 0)
			$display("source_line_classifier_core verification clean");
		else
			$display("source_line_classifier_core verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_400_000;
		$display("source_line_classifier_core verification failed");
		$finish;
	end

endmodule

// ===== source_line_classifier_core.f =====
sv/slc_pkg.sv
sv/slc_line_fsm.sv
sv/source_line_classifier_core.sv
bench/tb.sv
